### rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and defaults shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LIST   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] priority_req;
    logic        [7:0]  payload;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] entry_priority;
    logic        [7:0]  entry_payload;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic        [7:0]  data;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   fresh;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

endpackage
`default_nettype wire

### rtl/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and moves it left or right.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       occupied,
  input  wire logic       is_tail,
  input  wire entry_t     left_entry,
  input  wire logic       left_gt,
  input  wire entry_t     right_entry,
  input  wire entry_t     head_entry,
  output entry_t          entry,
  output logic            gt
);

  entry_t entry_next;

  // an empty slot counts as greater so the new entry lands at the tail
  assign gt = !occupied || (entry.prio > ctrl.fresh.prio);

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      OP_INSERT: begin
        if (gt) begin
          entry_next = left_gt ? left_entry : ctrl.fresh;
        end
      end
      OP_REMOVE: entry_next = right_entry;
      OP_ROTATE: entry_next = is_tail ? head_entry : right_entry;
      default:   entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

### rtl/sorted_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a chain of cells, smallest at head.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready) and results leave on rsp (valid/ready).
// An insert places the entry behind all entries of equal or smaller priority value;
// a remove drops the head; a list streams every entry from head to tail.
// Insert and remove act on all cells at once: on insert every cell compares
// its priority with the new one in parallel and shifts by one place. A single
// result is registered on rsp the cycle after the request is taken.
// A list rotates the chain one place per cycle while rsp is not stalled, and
// the head cell feeds the output register, so after n steps for n entries the
// order is back as it was. An empty list or remove gives status empty; an
// insert into a full queue gives status full and changes nothing.
// Kind three is ignored and gives no result.
// Reset empties the queue and drops any pending result. While rsp is
// stalled, req_ready stays low and a running list pauses in place.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] list_idx, list_idx_next;
  rsp_t          rsp_next;
  logic          rsp_load;
  logic          out_free;
  logic          accept;
  cell_ctrl_t    ctrl;
  entry_t        cells [QUEUE_DEPTH];
  logic          gt    [QUEUE_DEPTH];

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign accept    = req_valid && req_ready;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_t left_e, right_e;
      logic   left_g;
      if (i == 0) begin : g_first
        assign left_e = '0;
        assign left_g = 1'b0;
      end else begin : g_mid
        assign left_e = cells[i-1];
        assign left_g = gt[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_end
        assign right_e = cells[i];
      end else begin : g_inner
        assign right_e = cells[i+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (CW'(i) < count),
        .is_tail     (CW'(i) == count - CW'(1)),
        .left_entry  (left_e),
        .left_gt     (left_g),
        .right_entry (right_e),
        .head_entry  (cells[0]),
        .entry       (cells[i]),
        .gt          (gt[i])
      );
    end
  endgenerate

  always_comb begin
    state_next    = state;
    count_next    = count;
    list_idx_next = list_idx;
    rsp_load      = 1'b0;
    rsp_next      = '0;
    ctrl.op       = OP_HOLD;
    ctrl.fresh    = '{prio: req.priority_req, data: req.payload};
    rsp_next.last = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.kind)
            KIND_INSERT: begin
              rsp_load = 1'b1;
              if (count == CW'(QUEUE_DEPTH)) begin
                rsp_next.status = STATUS_FULL;
              end else begin
                rsp_next.status = STATUS_OK;
                ctrl.op         = OP_INSERT;
                count_next      = count + CW'(1);
              end
            end
            KIND_REMOVE: begin
              rsp_load = 1'b1;
              if (count == '0) begin
                rsp_next.status = STATUS_EMPTY;
              end else begin
                rsp_next.status = STATUS_OK;
                ctrl.op         = OP_REMOVE;
                count_next      = count - CW'(1);
              end
            end
            KIND_LIST: begin
              if (count == '0) begin
                rsp_load        = 1'b1;
                rsp_next.status = STATUS_EMPTY;
              end else begin
                state_next    = S_LIST;
                list_idx_next = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          rsp_load                = 1'b1;
          rsp_next.status         = STATUS_OK;
          rsp_next.entry_priority = cells[0].prio;
          rsp_next.entry_payload  = cells[0].data;
          rsp_next.last           = (list_idx == count - CW'(1));
          ctrl.op                 = OP_ROTATE;
          list_idx_next           = list_idx + CW'(1);
          if (rsp_next.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      list_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      list_idx <= list_idx_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (accept && req.kind == KIND_INSERT && count != CW'(QUEUE_DEPTH))
    |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !rsp_load)
    else $error("pending result overwritten");

  a_list_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST && rsp_load && rsp_next.last) |=> state == S_IDLE)
    else $error("list did not finish on its last entry");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count >= CW'(2)) |-> cells[0].prio <= cells[1].prio)
    else $error("head entries out of order");

endmodule
`default_nettype wire
